[rtl/core/mcm_pkg.sv]
// Shared constants and types for the multimode carrier modulator.
// Holds register indexes, mode codes, reset values and the control/status
// structs that join the controller to the datapath. No dependencies.
package mcm_pkg;

  // Fixed field widths of the sample and configuration interfaces.
  localparam int SAMPLE_W    = 16;
  localparam int MSG_W       = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CARRIER_STEP = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MARK_STEP    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPACE_STEP   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_FM_GAIN      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_PM_GAIN      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_AM_DEPTH     = 3'd6;

  // Modulation mode codes; the two remaining codes give a silent output.
  localparam logic [2:0] MODE_ASK = 3'd0;
  localparam logic [2:0] MODE_AM  = 3'd1;
  localparam logic [2:0] MODE_FSK = 3'd2;
  localparam logic [2:0] MODE_FM  = 3'd3;
  localparam logic [2:0] MODE_PSK = 3'd4;
  localparam logic [2:0] MODE_PM  = 3'd5;

  // Register values after reset.
  localparam logic [2:0]  RST_MODE         = MODE_FM;
  localparam logic [31:0] RST_CARRIER_STEP = 32'd214748365;
  localparam logic [31:0] RST_MARK_STEP    = 32'd322122547;
  localparam logic [31:0] RST_SPACE_STEP   = 32'd107374182;
  localparam logic [30:0] RST_FM_GAIN      = 31'd85899346;
  localparam logic [30:0] RST_PM_GAIN      = 31'd1073741824;
  localparam logic [15:0] RST_AM_DEPTH     = 16'd32768;

  // Step commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic mul;
    logic phase;
    logic look;
    logic scale;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic out_blocked;
  } dp_status_t;

endpackage

[rtl/core/mcm_ctrl.sv]
// Sequencing controller of the multimode carrier modulator.
// Steps one accepted beat through the datapath; depends on mcm_pkg.
module mcm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcm_pkg::dp_status_t status,
  output mcm_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_PHASE = 6'b000100,
    ST_LOOK  = 6'b001000,
    ST_SCALE = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and the command for the current step.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_PHASE;
      end
      ST_PHASE: begin
        cmd.phase  = 1'b1;
        state_next = ST_LOOK;
      end
      ST_LOOK: begin
        cmd.look   = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // Wait here while the previous result still sits unread.
        if (!status.out_blocked) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/mcm_datapath.sv]
// Datapath of the multimode carrier modulator: configuration registers,
// phase accumulators, multipliers, quarter-wave sine table and output
// register. Driven by mcm_ctrl commands; depends on mcm_pkg.
module mcm_datapath #(
  parameter int PHASE_BITS    = 32,
  parameter int LUT_ADDR_BITS = 10
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_wr_en,
  input  logic [mcm_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [mcm_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic                                    msg_bit,
  input  logic signed [mcm_pkg::MSG_W-1:0]        msg_sample,
  input  logic                                    restart,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [mcm_pkg::SAMPLE_W-1:0]     out_sample,
  input  mcm_pkg::dp_cmd_t                        cmd,
  output mcm_pkg::dp_status_t                     status
);

  // Sine table geometry: one quarter wave of QSIZE+1 magnitudes.
  localparam int QBITS  = LUT_ADDR_BITS - 2;
  localparam int QSIZE  = 1 << QBITS;
  localparam int MAG_W  = mcm_pkg::SAMPLE_W - 1;
  localparam int ROM_W  = (QSIZE + 1) * MAG_W;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] AMP         = (64'd1 << MAG_W) - 64'd1;
  localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                64'd110, 64'd156, 64'd210};

  // Arithmetic widths.
  localparam int GAIN_PROD_W = 32 + mcm_pkg::MSG_W;
  localparam int DEV_W       = GAIN_PROD_W - 15;
  localparam int FACTOR_W    = 17 + mcm_pkg::MSG_W;
  localparam int AM_PROD_W   = mcm_pkg::SAMPLE_W + FACTOR_W;
  localparam int AM_Q_W      = AM_PROD_W - 31;

  localparam logic signed [FACTOR_W-1:0]  AM_UNITY = FACTOR_W'(64'd2147483648);
  localparam logic signed [AM_PROD_W-1:0] AM_HALF  = AM_PROD_W'(64'd1073741824);
  localparam logic signed [AM_Q_W-1:0] SAT_MAX =
    AM_Q_W'((64'sd1 <<< (mcm_pkg::SAMPLE_W - 1)) - 64'sd1);
  localparam logic signed [AM_Q_W-1:0] SAT_MIN =
    AM_Q_W'(-(64'sd1 <<< (mcm_pkg::SAMPLE_W - 1)));

  localparam logic [PHASE_BITS-1:0]    HALF_TURN = {1'b1, {(PHASE_BITS-1){1'b0}}};
  localparam logic [LUT_ADDR_BITS-2:0] QSIZE_IDX = {1'b1, {QBITS{1'b0}}};

  // Quarter-wave sine magnitude: Taylor series through x^15 in Q30,
  // clamped to one and scaled to the full-scale amplitude.
  function automatic logic [MAG_W-1:0] quarter_mag(input int unsigned j);
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] s;
    logic [63:0]        mag;
    x = (HALF_PI_Q30 * 64'(j)) >> QBITS;
    t = x;
    s = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      t = (t * x) >> 30;
      t = ((t * x) >> 30) / TAYLOR_DIV[n];
      if ((n % 2) == 1) begin
        s = s - $signed(t);
      end else begin
        s = s + $signed(t);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    if (s > 64'sd1073741824) begin
      s = 64'sd1073741824;
    end
    mag = (64'(s) * AMP + (64'd1 << 29)) >> 30;
    return mag[MAG_W-1:0];
  endfunction

  function automatic logic [ROM_W-1:0] build_rom();
    logic [ROM_W-1:0] rom;
    rom = '0;
    for (int k = 0; k <= QSIZE; k++) begin
      rom[k*MAG_W +: MAG_W] = quarter_mag(k);
    end
    return rom;
  endfunction

  localparam logic [ROM_W-1:0] SINE_ROM = build_rom();

  // Configuration registers.
  logic [2:0]  mode;
  logic [31:0] carrier_step;
  logic [31:0] mark_step;
  logic [31:0] space_step;
  logic [30:0] fm_gain;
  logic [30:0] pm_gain;
  logic [15:0] am_depth;

  // Item and working registers.
  logic                              item_bit;
  logic signed [mcm_pkg::MSG_W-1:0]  item_msg;
  logic                              item_restart;
  logic [PHASE_BITS-1:0]             time_phase;
  logic [PHASE_BITS-1:0]             mod_phase;
  logic [PHASE_BITS-1:0]             lookup_phase;
  logic signed [GAIN_PROD_W-1:0]     gain_prod;
  logic signed [FACTOR_W-1:0]        depth_prod;
  logic signed [FACTOR_W-1:0]        am_factor;
  logic signed [mcm_pkg::SAMPLE_W-1:0] carrier_smp;
  logic signed [AM_PROD_W-1:0]       am_prod;

  // Combinational values.
  logic [30:0]                       gain_sel;
  logic signed [DEV_W-1:0]           dev;
  logic [PHASE_BITS-1:0]             dev_ext;
  logic [PHASE_BITS-1:0]             carrier_ext;
  logic [PHASE_BITS-1:0]             fsk_ext;
  logic [PHASE_BITS-1:0]             mod_phase_next;
  logic [PHASE_BITS-1:0]             lookup_next;
  logic [LUT_ADDR_BITS-1:0]          lut_addr;
  logic [1:0]                        quad;
  logic [LUT_ADDR_BITS-2:0]          rom_idx;
  logic [MAG_W-1:0]                  mag;
  logic [mcm_pkg::SAMPLE_W-1:0]      mag_ext;
  logic signed [AM_PROD_W-1:0]       am_sum;
  logic signed [AM_Q_W-1:0]          am_q;
  logic signed [mcm_pkg::SAMPLE_W-1:0] y;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= mcm_pkg::RST_MODE;
      carrier_step <= mcm_pkg::RST_CARRIER_STEP;
      mark_step    <= mcm_pkg::RST_MARK_STEP;
      space_step   <= mcm_pkg::RST_SPACE_STEP;
      fm_gain      <= mcm_pkg::RST_FM_GAIN;
      pm_gain      <= mcm_pkg::RST_PM_GAIN;
      am_depth     <= mcm_pkg::RST_AM_DEPTH;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mcm_pkg::CFG_MODE:         mode         <= cfg_data[2:0];
        mcm_pkg::CFG_CARRIER_STEP: carrier_step <= cfg_data[31:0];
        mcm_pkg::CFG_MARK_STEP:    mark_step    <= cfg_data[31:0];
        mcm_pkg::CFG_SPACE_STEP:   space_step   <= cfg_data[31:0];
        mcm_pkg::CFG_FM_GAIN:      fm_gain      <= cfg_data[30:0];
        mcm_pkg::CFG_PM_GAIN:      pm_gain      <= cfg_data[30:0];
        mcm_pkg::CFG_AM_DEPTH:     am_depth     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Phase arithmetic for the phase step.
  assign gain_sel    = (mode == mcm_pkg::MODE_FM) ? fm_gain : pm_gain;
  assign dev         = $signed(gain_prod[GAIN_PROD_W-1:15]);
  assign dev_ext     = PHASE_BITS'(dev);
  assign carrier_ext = PHASE_BITS'(carrier_step);
  assign fsk_ext     = PHASE_BITS'(item_bit ? mark_step : space_step);

  always_comb begin
    mod_phase_next = mod_phase;
    lookup_next    = time_phase;
    case (mode)
      mcm_pkg::MODE_FSK: begin
        mod_phase_next = mod_phase + fsk_ext;
        lookup_next    = mod_phase_next;
      end
      mcm_pkg::MODE_FM: begin
        mod_phase_next = mod_phase + carrier_ext + dev_ext;
        lookup_next    = mod_phase_next;
      end
      mcm_pkg::MODE_PSK: begin
        lookup_next = time_phase + (item_bit ? HALF_TURN : '0);
      end
      mcm_pkg::MODE_PM: begin
        lookup_next = time_phase + dev_ext;
      end
      default: begin
        lookup_next = time_phase;
      end
    endcase
  end

  // Phase accumulators: cleared on a restart beat, advanced once per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_phase <= '0;
      mod_phase  <= '0;
    end else if (cmd.mul && item_restart) begin
      time_phase <= '0;
      mod_phase  <= '0;
    end else if (cmd.phase) begin
      time_phase <= time_phase + carrier_ext;
      mod_phase  <= mod_phase_next;
    end
  end

  // Sine table read with quadrant mirroring.
  assign lut_addr = lookup_phase[PHASE_BITS-1 -: LUT_ADDR_BITS];
  assign quad     = lut_addr[LUT_ADDR_BITS-1 -: 2];
  assign rom_idx  = quad[0] ? (QSIZE_IDX - {1'b0, lut_addr[QBITS-1:0]})
                            : {1'b0, lut_addr[QBITS-1:0]};
  assign mag      = SINE_ROM[rom_idx*MAG_W +: MAG_W];
  assign mag_ext  = {1'b0, mag};

  // Item capture and the working pipeline of one item.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_bit     <= msg_bit;
      item_msg     <= msg_sample;
      item_restart <= restart;
    end
    if (cmd.mul) begin
      gain_prod  <= GAIN_PROD_W'($signed({1'b0, gain_sel})) * GAIN_PROD_W'(item_msg);
      depth_prod <= FACTOR_W'($signed({1'b0, am_depth})) * FACTOR_W'(item_msg);
    end
    if (cmd.phase) begin
      lookup_phase <= lookup_next;
      am_factor    <= AM_UNITY + depth_prod;
    end
    if (cmd.look) begin
      carrier_smp <= quad[1] ? -$signed(mag_ext) : $signed(mag_ext);
    end
    if (cmd.scale) begin
      am_prod <= AM_PROD_W'(carrier_smp) * AM_PROD_W'(am_factor);
    end
  end

  // AM rounding and saturation, and the final selection by mode.
  assign am_sum = am_prod + AM_HALF;
  assign am_q   = $signed(am_sum[AM_PROD_W-1:31]);

  always_comb begin
    y = '0;
    case (mode)
      mcm_pkg::MODE_ASK: begin
        y = item_bit ? carrier_smp : '0;
      end
      mcm_pkg::MODE_AM: begin
        if (am_q > SAT_MAX) begin
          y = SAT_MAX[mcm_pkg::SAMPLE_W-1:0];
        end else if (am_q < SAT_MIN) begin
          y = SAT_MIN[mcm_pkg::SAMPLE_W-1:0];
        end else begin
          y = am_q[mcm_pkg::SAMPLE_W-1:0];
        end
      end
      mcm_pkg::MODE_FSK, mcm_pkg::MODE_FM, mcm_pkg::MODE_PSK, mcm_pkg::MODE_PM: begin
        y = carrier_smp;
      end
      default: begin
        y = '0;
      end
    endcase
  end

  // Output register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sample <= y;
    end
  end

  assign status.out_blocked = out_valid && !out_ready;

endmodule

[rtl/core/multimode_carrier_modulator.sv]
// Multimode carrier modulator (ASK, AM, FSK, FM, PSK, PM) on a phase
// accumulator and quarter-wave sine table. Each input beat is captured at its
// accepting edge and reaches the output register after the gain and depth
// multiply, phase update, sine lookup and AM scaling steps, and waits before
// the output register while the previous result there is still unread. The
// controller walks one beat at a time through these steps and takes no new
// beat until the current one is in the output register. There is no clearing
// pass after reset. Depends on mcm_pkg, mcm_ctrl and mcm_datapath.
module multimode_carrier_modulator #(
  parameter int PHASE_BITS    = 32,
  parameter int LUT_ADDR_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [mcm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mcm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                msg_bit,
  input  logic signed [mcm_pkg::MSG_W-1:0]    msg_sample,
  input  logic                                restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mcm_pkg::SAMPLE_W-1:0] out_sample
);

  mcm_pkg::dp_cmd_t    cmd;
  mcm_pkg::dp_status_t status;

  // Step sequencer.
  mcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic, phase state and output register.
  mcm_datapath #(
    .PHASE_BITS    (PHASE_BITS),
    .LUT_ADDR_BITS (LUT_ADDR_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .msg_bit    (msg_bit),
    .msg_sample (msg_sample),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

[rtl/core/mcm_checker.sv]
// Port-level checks for the multimode carrier modulator, bound to the top
// level. Depends on mcm_pkg and multimode_carrier_modulator.
module mcm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [mcm_pkg::SAMPLE_W-1:0] out_sample
);

  // Reset leaves the block ready for a beat with nothing to deliver.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

  // Only one beat is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a beat is being processed");

  // With the output register empty, the result arrives with no stall.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid) |-> ##5 !out_valid ##1 out_valid)
    else $error("result not delivered at the expected cycle");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sample)))
    else $error("output beat changed while stalled");

endmodule

bind multimode_carrier_modulator mcm_checker u_checker (.*);
